FILE: design/flash_byte_write_word_packer_unit_assert.svh
// Assertion macros used by the packer RTL.
`ifndef FLASH_BYTE_WRITE_WORD_PACKER_UNIT_ASSERT_SVH
`define FLASH_BYTE_WRITE_WORD_PACKER_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define FBWP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define FBWP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/fbwp_pkg.sv
`timescale 1ns / 1ps
package fbwp_pkg;

	localparam int ADDR_W     = 32;
	localparam int WORD_W     = 32;
	localparam int BYTE_W     = 8;
	localparam int LANES      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	localparam logic [ADDR_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;
	localparam logic [ADDR_W-1:0] OFFSET_BITS = 32'h0000_0003;
	localparam logic [ADDR_W-1:0] WORD_STEP   = 32'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_BASE  = 2'd0,
		REG_WINDOW_BASE = 2'd1,
		REG_LANE_ORDER  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [WORD_W-1:0] mask;
	} lanes_t;

	typedef struct packed {
		logic [ADDR_W-1:0] word_addr;
		logic [WORD_W-1:0] word_data;
		logic [WORD_W-1:0] lane_mask;
		logic              end_of_write;
	} result_t;

	// Place gathered bytes (offset k in bits 8k+7..8k) into their output lanes.
	function automatic lanes_t pack_lanes(logic [WORD_W-1:0] gw, logic [LANES-1:0] gm,
			logic order);
		lanes_t r;
		r = '0;
		for (int k = 0; k < LANES; k++) begin
			if (gm[k]) begin
				if (order) begin
					r.data[BYTE_W*k +: BYTE_W] = gw[BYTE_W*k +: BYTE_W];
					r.mask[BYTE_W*k +: BYTE_W] = '1;
				end else begin
					r.data[BYTE_W*(LANES-1-k) +: BYTE_W] = gw[BYTE_W*k +: BYTE_W];
					r.mask[BYTE_W*(LANES-1-k) +: BYTE_W] = '1;
				end
			end
		end
		return r;
	endfunction

endpackage

FILE: design/fbwp_intf.sv
`timescale 1ns / 1ps
interface fbwp_item_if;
	logic        valid;
	logic        ready;
	logic        start_req;
	logic [31:0] flash_addr;
	logic [7:0]  data_byte;
	logic        last;

	modport source (output valid, output start_req, output flash_addr, output data_byte,
		output last, input ready);
	modport sink (input valid, input start_req, input flash_addr, input data_byte,
		input last, output ready);
endinterface

interface fbwp_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] word_addr;
	logic [31:0] word_data;
	logic [31:0] lane_mask;
	logic        end_of_write;

	modport source (output valid, output word_addr, output word_data, output lane_mask,
		output end_of_write, input ready);
	modport sink (input valid, input word_addr, input word_data, input lane_mask,
		input end_of_write, output ready);
endinterface

interface fbwp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: design/flash_byte_write_word_packer_unit.sv
`timescale 1ns / 1ps
// Packs a byte stream of flash writes into aligned 32-bit words for the write window.
// One byte beat is taken per cycle while ready is high; each accepted byte updates the
// gather state in the same cycle and its finished words are registered into a four-entry
// result queue, whose oldest word is shown on the output. A start beat that interrupts
// a partial word can yield two words, which the queue absorbs; the input is held off
// only while fewer than two queue slots are free, so with the output taking a word
// every cycle the input runs at one beat per cycle unless two-word beats crowd the queue.
// Configuration writes are always taken and should only be issued while the block is idle.
`include "flash_byte_write_word_packer_unit_assert.svh"

module flash_byte_write_word_packer_unit
	import fbwp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	fbwp_cfg_if.sink     cfg,
	fbwp_item_if.sink    item_in,
	fbwp_word_if.source  word_out
);

	logic [ADDR_W-1:0] range_base_q;
	logic [ADDR_W-1:0] window_base_q;
	logic              lane_order_q;

	logic [ADDR_W-1:0] cur_addr_q;
	logic [1:0]        lane_pos_q;
	logic [WORD_W-1:0] gword_q;
	logic [LANES-1:0]  gmask_q;
	logic              active_q;

	result_t           fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	logic              acc;
	logic              take;
	logic              flush;
	logic              emit;
	logic [ADDR_W-1:0] vaddr;
	logic [ADDR_W-1:0] base_addr;
	logic [1:0]        base_pos;
	logic [WORD_W-1:0] base_word;
	logic [LANES-1:0]  base_mask;
	logic [WORD_W-1:0] new_word;
	logic [LANES-1:0]  new_mask;
	lanes_t            flush_lanes;
	lanes_t            main_lanes;
	result_t           flush_res;
	result_t           main_res;
	result_t           res0;
	logic [1:0]        push_n;
	logic              pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_base_q  <= '0;
			window_base_q <= '0;
			lane_order_q  <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_RANGE_BASE:  range_base_q  <= cfg.wdata;
				REG_WINDOW_BASE: window_base_q <= cfg.wdata;
				REG_LANE_ORDER:  lane_order_q  <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	assign item_in.ready = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign acc  = item_in.valid && item_in.ready;
	assign take = acc && (item_in.start_req || active_q);

	always_comb begin
		vaddr     = window_base_q + (item_in.flash_addr - range_base_q);
		flush     = item_in.start_req && active_q && (gmask_q != '0);
		base_addr = item_in.start_req ? (vaddr & ~OFFSET_BITS) : cur_addr_q;
		base_pos  = item_in.start_req ? vaddr[1:0] : lane_pos_q;
		base_word = item_in.start_req ? '0 : gword_q;
		base_mask = item_in.start_req ? '0 : gmask_q;
		new_word  = base_word | (WORD_W'(item_in.data_byte) << {base_pos, 3'b000});
		new_mask  = base_mask | (LANES'(1) << base_pos);
		emit      = (base_pos == 2'd3) || item_in.last;

		flush_lanes = pack_lanes(gword_q, gmask_q, lane_order_q);
		main_lanes  = pack_lanes(new_word, new_mask, lane_order_q);

		flush_res.word_addr    = cur_addr_q;
		flush_res.word_data    = flush_lanes.data;
		flush_res.lane_mask    = flush_lanes.mask;
		flush_res.end_of_write = 1'b1;

		main_res.word_addr     = base_addr;
		main_res.word_data     = main_lanes.data;
		main_res.lane_mask     = main_lanes.mask;
		main_res.end_of_write  = item_in.last;

		res0   = flush ? flush_res : main_res;
		push_n = take ? (2'(flush) + 2'(emit)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_addr_q <= '0;
			lane_pos_q <= '0;
			gword_q    <= '0;
			gmask_q    <= '0;
			active_q   <= 1'b0;
		end else if (take) begin
			if (emit) begin
				gword_q    <= '0;
				gmask_q    <= '0;
				lane_pos_q <= '0;
				active_q   <= !item_in.last;
				cur_addr_q <= item_in.last ? base_addr : base_addr + WORD_STEP;
			end else begin
				gword_q    <= new_word;
				gmask_q    <= new_mask;
				lane_pos_q <= base_pos + 2'd1;
				active_q   <= 1'b1;
				cur_addr_q <= base_addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_ptr_q + FIFO_AW'(1)] <= main_res;
		end
	end

	assign pop = word_out.valid && word_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			cnt_q    <= cnt_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

	assign word_out.valid        = (cnt_q != '0);
	assign word_out.word_addr    = fifo_q[rd_ptr_q].word_addr;
	assign word_out.word_data    = fifo_q[rd_ptr_q].word_data;
	assign word_out.lane_mask    = fifo_q[rd_ptr_q].lane_mask;
	assign word_out.end_of_write = fifo_q[rd_ptr_q].end_of_write;

	`FBWP_ASSERT(a_cnt_bound, cnt_q <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")
	`FBWP_ASSERT(a_mask_needs_active, (gmask_q != '0) |-> active_q, "bytes gathered while idle")
	`FBWP_ASSERT(a_idle_clean, !active_q |-> (gmask_q == '0 && lane_pos_q == 2'd0), "idle state not clean")
	`FBWP_ASSERT(a_cnt_step, 1'b1 |=> (cnt_q <= $past(cnt_q) + FIFO_CW'(2)), "queue grew by more than two")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import fbwp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int CFG_SETTLE     = 4;
	localparam int PHASES         = 6;
	localparam int PHASE_BEATS    = 180;

	logic clk;
	logic arst_n;

	fbwp_cfg_if  cfg_bus ();
	fbwp_item_if byte_bus ();
	fbwp_word_if word_bus ();

	flash_byte_write_word_packer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_bus),
		.item_in  (byte_bus),
		.word_out (word_bus)
	);

	logic [ADDR_W-1:0] range_base_q;
	logic [ADDR_W-1:0] window_base_q;
	logic              order_q;

	logic [ADDR_W-1:0] wr_addr;
	logic [1:0]        wr_pos;
	logic [WORD_W-1:0] wr_bytes;
	logic [LANES-1:0]  wr_lanes;
	logic              wr_open;

	result_t packed_words_q[$];

	int errors;
	int byte_beats;
	int stall_cycles;
	int rx_hold_len;
	int rx_left;
	int rx_gap;
	bit rx_idle;
	bit tx_idle;

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom;
		if (r < 75)
			return $urandom_range(0, 15);
		if (r < 95)
			return ALL_ONES - $urandom_range(0, 15);
		return {8'($urandom_range(0, 255)), 24'h0};
	endfunction

	function automatic result_t form_word(logic eow);
		result_t w;
		int pos;
		w = '0;
		w.word_addr = wr_addr;
		for (int k = 0; k < LANES; k++) begin
			if (wr_lanes[k]) begin
				pos = order_q ? k : LANES - 1 - k;
				w.word_data[BYTE_W*pos +: BYTE_W] = wr_bytes[BYTE_W*k +: BYTE_W];
				w.lane_mask[BYTE_W*pos +: BYTE_W] = '1;
			end
		end
		w.end_of_write = eow;
		return w;
	endfunction

	function automatic void pack_byte(logic st, logic [ADDR_W-1:0] fa, logic [BYTE_W-1:0] b,
			logic lst);
		logic [ADDR_W-1:0] va;
		if (st) begin
			if (wr_open && wr_lanes != '0)
				packed_words_q.push_back(form_word(1'b1));
			va = window_base_q + (fa - range_base_q);
			wr_addr = va & ~OFFSET_BITS;
			wr_pos = va[1:0];
			wr_bytes = '0;
			wr_lanes = '0;
			wr_open = 1'b1;
		end else if (!wr_open) begin
			return;
		end
		byte_beats++;
		wr_bytes[BYTE_W*wr_pos +: BYTE_W] = b;
		wr_lanes[wr_pos] = 1'b1;
		if (wr_pos == 2'd3 || lst) begin
			packed_words_q.push_back(form_word(lst));
			wr_bytes = '0;
			wr_lanes = '0;
			wr_pos = 2'd0;
			if (lst)
				wr_open = 1'b0;
			else
				wr_addr = wr_addr + WORD_STEP;
		end else begin
			wr_pos = wr_pos + 2'd1;
		end
	endfunction

	task automatic send_byte(logic st, logic [ADDR_W-1:0] fa, logic [BYTE_W-1:0] b, logic lst);
		int gap;
		gap = tx_idle ? pick_gap() : 0;
		if (gap > 0) begin
			byte_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_bus.valid      <= 1'b1;
		byte_bus.start_req  <= st;
		byte_bus.flash_addr <= fa;
		byte_bus.data_byte  <= b;
		byte_bus.last       <= lst;
		@(posedge clk);
		while (!byte_bus.ready) @(posedge clk);
		pack_byte(st, fa, b, lst);
	endtask

	task automatic send_write(logic [ADDR_W-1:0] fa, int len, bit closed);
		for (int i = 0; i < len; i++)
			send_byte(i == 0, (i == 0) ? fa : ADDR_W'($urandom), BYTE_W'($urandom),
				closed && i == len - 1);
	endtask

	task automatic wait_words_done();
		byte_bus.valid <= 1'b0;
		while (packed_words_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [ADDR_W-1:0] val);
		wait_words_done();
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.wdata <= val;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		case (idx)
			REG_RANGE_BASE:  range_base_q = val;
			REG_WINDOW_BASE: window_base_q = val;
			REG_LANE_ORDER:  order_q = val[0];
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic test_directed();
		write_reg(REG_RANGE_BASE, '0);
		write_reg(REG_WINDOW_BASE, '0);
		write_reg(REG_LANE_ORDER, ADDR_W'(1'b0));
		send_byte(1'b1, '0, 8'hFF, 1'b1);
		send_write(32'h0000_0100, 4, 1'b1);
		send_write(32'h0000_0203, 3, 1'b1);
		send_byte(1'b0, ALL_ONES, 8'h00, 1'b1);
		send_byte(1'b0, '0, 8'hFF, 1'b0);
		send_write(32'h0000_0301, 2, 1'b0);
		send_write(ALL_ONES, 2, 1'b1);
		send_write(32'h0000_0400, 4, 1'b0);
		send_byte(1'b1, 32'h0000_0500, 8'hA5, 1'b1);
		// change lane order with a partial word gathered
		send_write(32'h0000_0600, 2, 1'b0);
		write_reg(REG_LANE_ORDER, ADDR_W'(1'b1));
		send_byte(1'b0, '0, 8'h5A, 1'b0);
		send_byte(1'b0, '0, 8'hC3, 1'b1);
		write_reg(REG_RANGE_BASE, 32'h8000_0000);
		write_reg(REG_WINDOW_BASE, 32'hFFFF_FFFA);
		send_write(32'h8000_0004, 3, 1'b1);
		send_write(32'h0000_0001, 2, 1'b1);
		write_reg(REG_RANGE_BASE, ALL_ONES);
		write_reg(REG_WINDOW_BASE, ALL_ONES);
		send_write('0, 1, 1'b1);
		wait_words_done();
	endtask

	task automatic test_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold_len = 120;
		for (int i = 0; i < 10; i++)
			send_write(pick_addr(), $urandom_range(4, 8), 1'b1);
		wait_words_done();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_sender_pause();
		send_write(pick_addr(), 6, 1'b0);
		// hold the write open until every word is out
		wait_words_done();
		send_byte(1'b0, '0, BYTE_W'($urandom), 1'b0);
		send_byte(1'b0, '0, BYTE_W'($urandom), 1'b1);
		wait_words_done();
	endtask

	task automatic test_random_phases();
		int goal;
		int r;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_RANGE_BASE, '0);
					write_reg(REG_WINDOW_BASE, '0);
					write_reg(REG_LANE_ORDER, ADDR_W'(1'b0));
				end
				1: begin
					write_reg(REG_RANGE_BASE, ALL_ONES);
					write_reg(REG_WINDOW_BASE, ALL_ONES);
					write_reg(REG_LANE_ORDER, ADDR_W'(1'b1));
				end
				default: begin
					write_reg(REG_RANGE_BASE, pick_addr());
					write_reg(REG_WINDOW_BASE, pick_addr());
					write_reg(REG_LANE_ORDER, ADDR_W'(phase[0]));
				end
			endcase
			tx_idle = (phase != 2);
			rx_idle = (phase != 2) && (phase != 4);
			goal = byte_beats + PHASE_BEATS;
			while (byte_beats < goal) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					send_write(pick_addr(), ($urandom_range(0, 9) < 7) ?
						$urandom_range(1, 8) : $urandom_range(9, 20), 1'b1);
				else if (r < 90)
					send_write(pick_addr(), $urandom_range(1, 6), 1'b0);
				else
					send_byte(1'($urandom), pick_addr(), BYTE_W'($urandom), 1'($urandom));
			end
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	always @(posedge clk) begin
		if (rx_hold_len > 0) begin
			rx_left = rx_hold_len;
			rx_hold_len = 0;
		end
		if (rx_left > 0) begin
			rx_left--;
			word_bus.ready <= 1'b0;
		end else begin
			rx_gap = rx_idle ? pick_gap() : 0;
			if (rx_gap > 0) begin
				rx_left = rx_gap - 1;
				word_bus.ready <= 1'b0;
			end else begin
				word_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_words
		result_t want;
		if (arst_n && word_bus.valid && word_bus.ready) begin
			if (packed_words_q.size() == 0) begin
				$error("unexpected word beat: word_addr %h word_data %h",
					word_bus.word_addr, word_bus.word_data);
				errors++;
			end else begin
				want = packed_words_q.pop_front();
				if (word_bus.word_addr !== want.word_addr) begin
					$error("word_addr expected %h actual %h", want.word_addr, word_bus.word_addr);
					errors++;
				end
				if (word_bus.word_data !== want.word_data) begin
					$error("word_data expected %h actual %h", want.word_data, word_bus.word_data);
					errors++;
				end
				if (word_bus.lane_mask !== want.lane_mask) begin
					$error("lane_mask expected %h actual %h", want.lane_mask, word_bus.lane_mask);
					errors++;
				end
				if (word_bus.end_of_write !== want.end_of_write) begin
					$error("end_of_write expected %b actual %b", want.end_of_write,
						word_bus.end_of_write);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_bus.valid && byte_bus.ready) || (word_bus.valid && word_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_RANGE_BASE;
		cfg_bus.wdata = '0;
		byte_bus.valid = 1'b0;
		byte_bus.start_req = 1'b0;
		byte_bus.flash_addr = '0;
		byte_bus.data_byte = '0;
		byte_bus.last = 1'b0;
		word_bus.ready = 1'b0;
		range_base_q = '0;
		window_base_q = '0;
		order_q = 1'b0;
		wr_addr = '0;
		wr_pos = '0;
		wr_bytes = '0;
		wr_lanes = '0;
		wr_open = 1'b0;
		errors = 0;
		byte_beats = 0;
		stall_cycles = 0;
		rx_hold_len = 0;
		rx_left = 0;
		rx_gap = 0;
		rx_idle = 1'b1;
		tx_idle = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_sender_pause();
		test_random_phases();
		wait_words_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/fbwp_pkg.sv
design/fbwp_intf.sv
design/flash_byte_write_word_packer_unit.sv
tb/testbench.sv
